// ----- src/bfps_pkg.sv -----
// ----------------------------------------------------------------------------
// bfps_pkg: shared types and constants for the bit-sliced Fitch step
// Request and response payloads, lane and cost-tree interfaces, and codes.
// ----------------------------------------------------------------------------
package bfps_pkg;

  localparam int STATE_LANES    = 4;
  localparam int MAX_WORDS      = 64;
  localparam int SITES_PER_WORD = 64;
  localparam int NUM_STATES     = 4;

  localparam int WEIGHT_DEPTH = MAX_WORDS * SITES_PER_WORD;
  localparam int ROW_W        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int SITE_W       = $clog2(SITES_PER_WORD);
  localparam int GROUPS       = 8;
  localparam int GROUP_SZ     = SITES_PER_WORD / GROUPS;

  localparam int WEIGHT_W = 24;
  localparam int GSUM_W   = 27;
  localparam int GCNT_W   = 4;
  localparam int COST_W   = 30;
  localparam int TOTAL_W  = 48;
  localparam int POS_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_STATES  = 2'd0,
    CFG_WEIGHTED_WORDS = 2'd1,
    CFG_BASE_COST      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        opcode;
    logic [63:0] child_a_state0;
    logic [63:0] child_a_state1;
    logic [63:0] child_a_state2;
    logic [63:0] child_a_state3;
    logic [63:0] child_b_state0;
    logic [63:0] child_b_state1;
    logic [63:0] child_b_state2;
    logic [63:0] child_b_state3;
    logic [11:0] position;
    logic [23:0] weight_value;
    logic        last_word;
  } in_req_t;

  typedef struct packed {
    logic [63:0] parent_state0;
    logic [63:0] parent_state1;
    logic [63:0] parent_state2;
    logic [63:0] parent_state3;
    logic [29:0] word_cost;
    logic [47:0] total_cost;
    logic        last_of_run;
  } out_rsp_t;

  // What one state lane reports to the merging stage.
  typedef struct packed {
    logic [SITES_PER_WORD-1:0] isect;
    logic [SITES_PER_WORD-1:0] uni;
  } lane_res_t;

  // Control for the cost tree, registered alongside the weight read.
  typedef struct packed {
    logic                      weighted;
    logic [SITES_PER_WORD-1:0] wmask;
    logic [SITES_PER_WORD-1:0] cmask;
  } cost_req_t;

endpackage

// ----- src/bfps_ram.sv -----
// ----------------------------------------------------------------------------
// bfps_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module bfps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bfps_state_lane.sv -----
// ----------------------------------------------------------------------------
// bfps_state_lane: one character-state lane of the Fitch step
// Forms the intersection and union of the two child sets for one state.
// ----------------------------------------------------------------------------
module bfps_state_lane (
  input  logic                               lane_en_i,
  input  logic [bfps_pkg::SITES_PER_WORD-1:0] a_i,
  input  logic [bfps_pkg::SITES_PER_WORD-1:0] b_i,
  output bfps_pkg::lane_res_t                res_o
);
  import bfps_pkg::*;

  // A lane that is not in use contributes nothing to either set.
  always_comb begin
    res_o.isect = lane_en_i ? (a_i & b_i) : '0;
    res_o.uni   = lane_en_i ? (a_i | b_i) : '0;
  end

endmodule

// ----- src/bfps_cost_tree.sv -----
// ----------------------------------------------------------------------------
// bfps_cost_tree: two-stage registered cost adder
// Sums the masked site weights, or counts empty sites scaled by 256, for one word.
// ----------------------------------------------------------------------------
module bfps_cost_tree (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  bfps_pkg::cost_req_t                   req_i,
  input  logic [bfps_pkg::WEIGHT_W-1:0]         weights_i [bfps_pkg::SITES_PER_WORD],
  output logic [bfps_pkg::COST_W-1:0]           cost_o
);
  import bfps_pkg::*;

  logic [GSUM_W-1:0] gsum_d [GROUPS];
  logic [GSUM_W-1:0] gsum_q [GROUPS];
  logic [GCNT_W-1:0] gcnt_d [GROUPS];
  logic [GCNT_W-1:0] gcnt_q [GROUPS];
  logic              weighted_q;
  logic [COST_W-1:0] cost_d;
  logic [COST_W-1:0] cost_q;

  // First stage: eight groups of eight sites each.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gsum_d[g] = '0;
      gcnt_d[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (req_i.wmask[g*GROUP_SZ+k]) begin
          gsum_d[g] = gsum_d[g] + GSUM_W'(weights_i[g*GROUP_SZ+k]);
        end
        gcnt_d[g] = gcnt_d[g] + GCNT_W'(req_i.cmask[g*GROUP_SZ+k]);
      end
    end
  end

  // Second stage: combine the groups and pick the cost kind.
  always_comb begin
    logic [COST_W-1:0] wsum;
    logic [COST_W-1:0] csum;
    wsum = '0;
    csum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      wsum = wsum + COST_W'(gsum_q[g]);
      csum = csum + COST_W'(gcnt_q[g]);
    end
    cost_d = weighted_q ? wsum : (csum << 8);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gsum_q     <= gsum_d;
      gcnt_q     <= gcnt_d;
      weighted_q <= req_i.weighted;
      cost_q     <= cost_d;
    end
  end

  assign cost_o = cost_q;

endmodule

// ----- src/bitsliced_fitch_parsimony_step.sv -----
// ----------------------------------------------------------------------------
// bitsliced_fitch_parsimony_step: 64-site bit-parallel Fitch parsimony step
// State lanes form parent sets; a weight RAM bank and cost tree score words.
// ----------------------------------------------------------------------------
// An update request passes stage 1, the cost tree and the output register before
// its response appears. Throughput: one request per cycle while the output is not
// stalled; the saturating run-total accumulator in the last stage sets that rate.
// Load requests write one site weight and give no response.
// Reset clears all valid bits, the run total and the registers (active_states
// four, weighted_words zero, base_cost zero); the weight store is not cleared.
module bitsliced_fitch_parsimony_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bfps_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bfps_pkg::out_rsp_t                  out_rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bfps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bfps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bfps_pkg::*;

  // Configuration registers. Writes are always taken.
  logic [2:0]          active_q;
  logic [6:0]          wwords_q;
  logic [WEIGHT_W-1:0] base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 3'd4;
      wwords_q <= '0;
      base_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE_STATES:  active_q <= cfg_data_i[2:0];
        CFG_WEIGHTED_WORDS: wwords_q <= cfg_data_i[6:0];
        CFG_BASE_COST:      base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only when a finished
  // response waits at the output and the output is stalled.
  logic en;
  logic accept;
  logic is_update;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign is_update  = (opcode_e'(in_req_i.opcode) == OP_UPDATE);

  logic [31:0] pos_ext;
  assign pos_ext = 32'(in_req_i.position);

  // State lanes. Requested lanes above the built count act as the built count.
  logic [2:0] lanes_used;
  assign lanes_used = (active_q > 3'(STATE_LANES)) ? 3'(STATE_LANES) : active_q;

  logic [SITES_PER_WORD-1:0] a_w [NUM_STATES];
  logic [SITES_PER_WORD-1:0] b_w [NUM_STATES];
  lane_res_t                 lane_res [NUM_STATES];

  assign a_w[0] = in_req_i.child_a_state0;
  assign a_w[1] = in_req_i.child_a_state1;
  assign a_w[2] = in_req_i.child_a_state2;
  assign a_w[3] = in_req_i.child_a_state3;
  assign b_w[0] = in_req_i.child_b_state0;
  assign b_w[1] = in_req_i.child_b_state1;
  assign b_w[2] = in_req_i.child_b_state2;
  assign b_w[3] = in_req_i.child_b_state3;

  for (genvar j = 0; j < NUM_STATES; j++) begin : g_lane
    bfps_state_lane u_lane (
      .lane_en_i ((j < STATE_LANES) && (3'(j) < lanes_used)),
      .a_i       (a_w[j]),
      .b_i       (b_w[j]),
      .res_o     (lane_res[j])
    );
  end

  // Merging stage: a site whose intersection is empty in every lane takes
  // the union and costs.
  logic [SITES_PER_WORD-1:0] any_isect;
  logic [SITES_PER_WORD-1:0] empty;
  logic [SITES_PER_WORD-1:0] par [NUM_STATES];

  always_comb begin
    any_isect = '0;
    for (int j = 0; j < NUM_STATES; j++) begin
      any_isect = any_isect | lane_res[j].isect;
    end
    empty = ~any_isect;
    for (int j = 0; j < NUM_STATES; j++) begin
      par[j] = lane_res[j].isect | (empty & lane_res[j].uni);
    end
  end

  // Weight store: one RAM per site bit, one row per word. A load writes the
  // RAM of its site bit; an update reads the same row of all of them.
  logic                load_we;
  logic [ROW_W-1:0]    load_row;
  logic [SITE_W-1:0]   load_site;
  logic [ROW_W-1:0]    read_row;
  logic [WEIGHT_W-1:0] weights [SITES_PER_WORD];

  assign load_we   = accept && !is_update && (pos_ext < 32'(WEIGHT_DEPTH));
  assign load_row  = pos_ext[SITE_W +: ROW_W];
  assign load_site = pos_ext[SITE_W-1:0];
  assign read_row  = pos_ext[ROW_W-1:0];

  for (genvar l = 0; l < SITES_PER_WORD; l++) begin : g_wram
    bfps_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_WORDS),
      .AW    (ROW_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (load_we && (load_site == SITE_W'(l))),
      .waddr_i (load_row),
      .wdata_i (in_req_i.weight_value),
      .re_i    (en),
      .raddr_i (read_row),
      .rdata_o (weights[l])
    );
  end

  // Stage 1: parent sets and cost masks, aligned with the weight read.
  logic                      weighted;
  logic                      in_store;
  logic                      s1_valid_q, s2_valid_q, s3_valid_q;
  logic [SITES_PER_WORD-1:0] s1_par_q [NUM_STATES];
  logic [SITES_PER_WORD-1:0] s2_par_q [NUM_STATES];
  logic [SITES_PER_WORD-1:0] s3_par_q [NUM_STATES];
  logic                      s1_last_q, s2_last_q, s3_last_q;
  cost_req_t                 s1_cost_q;
  logic [COST_W-1:0]         s3_cost;

  assign weighted = pos_ext < 32'(wwords_q);
  assign in_store = pos_ext < 32'(MAX_WORDS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept && is_update;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_par_q           <= par;
      s1_last_q          <= in_req_i.last_word;
      s1_cost_q.weighted <= weighted;
      // A weighted word beyond the store adds nothing.
      s1_cost_q.wmask    <= (weighted && in_store) ? empty : '0;
      s1_cost_q.cmask    <= empty;
      s2_par_q           <= s1_par_q;
      s2_last_q          <= s1_last_q;
      s3_par_q           <= s2_par_q;
      s3_last_q          <= s2_last_q;
    end
  end

  // Stages 2 and 3: the cost tree.
  bfps_cost_tree u_tree (
    .clk_i     (clk_i),
    .en_i      (en),
    .req_i     (s1_cost_q),
    .weights_i (weights),
    .cost_o    (s3_cost)
  );

  // Stage 4: saturating run total and the output register. The run total
  // clears after the word that closes a run.
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [TOTAL_W-1:0] run_q, run_d;
  logic [TOTAL_W-1:0] run_sum;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W:0]   run_wide;
  logic [TOTAL_W:0]   tot_wide;
  logic               out_valid_q;
  out_rsp_t           rsp_q;

  always_comb begin
    run_wide = {1'b0, run_q} + (TOTAL_W+1)'(s3_cost);
    run_sum  = run_wide[TOTAL_W] ? TOTAL_MAX : run_wide[TOTAL_W-1:0];
    tot_wide = {1'b0, run_sum} + (TOTAL_W+1)'(base_q);
    total    = tot_wide[TOTAL_W] ? TOTAL_MAX : tot_wide[TOTAL_W-1:0];
    run_d    = s3_last_q ? '0 : run_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        run_q <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_valid_q) begin
      rsp_q.parent_state0 <= s3_par_q[0];
      rsp_q.parent_state1 <= s3_par_q[1];
      rsp_q.parent_state2 <= s3_par_q[2];
      rsp_q.parent_state3 <= s3_par_q[3];
      rsp_q.word_cost     <= s3_cost;
      rsp_q.total_cost    <= total;
      rsp_q.last_of_run   <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // A word that closes a run leaves the run total at zero.
  a_run_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s3_valid_q && en && s3_last_q) |-> (run_q == '0))
    else $error("run total not cleared after last word");

  // A word leaving the cost tree reaches the output on the next cycle.
  a_stage_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && en) |=> out_valid_o)
    else $error("response lost between cost tree and output");

  // The running total always includes the cost of the word it reports.
  a_total_ge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.total_cost >= TOTAL_W'(out_rsp_o.word_cost)))
    else $error("total cost below word cost");

endmodule
